// ----- design/sgtl_pkg.sv -----
// Shared types and codes for the sorted identifier table lookup.
package sgtl_pkg;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam int GUID_W     = 64;
  localparam int PLAT_W     = 3;
  localparam int IDX_W      = 10;
  localparam int CFG_W      = 11;
  localparam int ENTRY_W    = 2 * GUID_W + PLAT_W;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic key_load;
  } dp_cmd_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic plat_eq;
  } dp_status_t;

endpackage

// ----- design/sorted_guid_table_lookup_unit.sv -----
// Top level of the sorted identifier table lookup.
// Write item: accepted with no result, in_stall stays low. Lookup: P probes,
// P <= ceil(log2(count+1)), each one table read and one compare. A hit then adds one
// read per slot in the back step and forward scan, plus a check where they stop at
// slot 0 or at count; a miss or an empty table skips both. Input stalls until the result
// is taken. Reset clears sequencer and entry_count, not the table.
module sorted_guid_table_lookup_unit import sgtl_pkg::*; #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [GUID_W-1:0] guid_high,
  input  logic [GUID_W-1:0] guid_low,
  input  logic [PLAT_W-1:0] platform_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic [IDX_W-1:0]  match_index
);

  localparam int AW = $clog2(MAX_ENTRIES);

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [AW-1:0] rd_addr;

  sgtl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .match_index (match_index),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .status      (status)
  );

  sgtl_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .entry_index   (entry_index),
    .guid_high     (guid_high),
    .guid_low      (guid_low),
    .platform_code (platform_code),
    .status        (status)
  );

endmodule

// ----- design/sgtl_datapath.sv -----
// Table memory, search key register and identifier comparator.
module sgtl_datapath import sgtl_pkg::*; #(
  parameter int MAX_ENTRIES = 1024,
  parameter int AW          = $clog2(MAX_ENTRIES)
) (
  input  logic              clk,
  input  dp_cmd_t           cmd,
  input  logic [AW-1:0]     rd_addr,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [GUID_W-1:0] guid_high,
  input  logic [GUID_W-1:0] guid_low,
  input  logic [PLAT_W-1:0] platform_code,
  output dp_status_t        status
);

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic [GUID_W-1:0]  key_high;
  logic [GUID_W-1:0]  key_low;
  logic [PLAT_W-1:0]  key_plat;
  logic               wr_in_range;

  logic [GUID_W-1:0]  rd_high;
  logic [GUID_W-1:0]  rd_low;
  logic [PLAT_W-1:0]  rd_plat;

  assign wr_in_range = ({22'b0, entry_index} < 32'(MAX_ENTRIES));

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in_range) begin
      mem[AW'(entry_index)] <= {guid_high, guid_low, platform_code};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.key_load) begin
      key_high <= guid_high;
      key_low  <= guid_low;
      key_plat <= platform_code;
    end
  end

  assign rd_high = rd_data[ENTRY_W-1 -: GUID_W];
  assign rd_low  = rd_data[PLAT_W +: GUID_W];
  assign rd_plat = rd_data[PLAT_W-1:0];

  always_comb begin
    status.eq      = (rd_high == key_high) && (rd_low == key_low);
    status.lt      = (rd_high < key_high) || ((rd_high == key_high) && (rd_low < key_low));
    status.plat_eq = (rd_plat == key_plat);
  end

endmodule

// ----- design/sgtl_ctrl.sv -----
// Lookup sequencer: binary search, back step over equal run, forward platform scan.
module sgtl_ctrl import sgtl_pkg::*; #(
  parameter int MAX_ENTRIES = 1024,
  parameter int AW          = $clog2(MAX_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic [IDX_W-1:0] match_index,
  output dp_cmd_t          cmd,
  output logic [AW-1:0]    rd_addr,
  input  dp_status_t       status
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROBE, ST_PCMP, ST_BACK, ST_BCMP, ST_FWD, ST_FCMP, ST_DONE
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] entry_count;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi_p1;
  logic [AW-1:0]    mid_q;
  logic [AW-1:0]    start;
  logic [CW-1:0]    scan;

  logic [CW-1:0]    count_clamped;
  logic [CW-1:0]    span;
  logic [CW-1:0]    mid_w;
  logic [AW-1:0]    mid;
  logic             accept;

  assign count_clamped = (XW'(entry_count) > XW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                             : CW'(entry_count);
  assign span   = hi_p1 - lo - CW'(1);
  assign mid_w  = lo + (span >> 1);
  assign mid    = mid_w[AW-1:0];
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd.wr_en    = accept && (req_type == REQ_WRITE);
    cmd.key_load = accept && (req_type == REQ_LOOKUP);
    cmd.rd_en    = 1'b0;
    rd_addr      = mid;
    unique case (state)
      ST_PROBE: begin
        cmd.rd_en = 1'b1;
        rd_addr   = mid;
      end
      ST_BACK: begin
        cmd.rd_en = 1'b1;
        rd_addr   = start - AW'(1);
      end
      ST_FWD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = scan[AW-1:0];
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      if (cfg_write) begin
        entry_count <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (req_type == REQ_LOOKUP)) begin
            if (count_clamped == '0) begin
              found       <= 1'b0;
              match_index <= '0;
              out_valid   <= 1'b1;
              state       <= ST_DONE;
            end else begin
              cnt   <= count_clamped;
              lo    <= '0;
              hi_p1 <= count_clamped;
              state <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          if (lo < hi_p1) begin
            mid_q <= mid;
            state <= ST_PCMP;
          end else begin
            found       <= 1'b0;
            match_index <= '0;
            out_valid   <= 1'b1;
            state       <= ST_DONE;
          end
        end
        ST_PCMP: begin
          priority if (status.eq) begin
            start <= mid_q;
            state <= ST_BACK;
          end else if (status.lt) begin
            lo    <= CW'(mid_q) + CW'(1);
            state <= ST_PROBE;
          end else begin
            hi_p1 <= CW'(mid_q);
            state <= ST_PROBE;
          end
        end
        ST_BACK: begin
          if (start == '0) begin
            scan  <= '0;
            state <= ST_FWD;
          end else begin
            state <= ST_BCMP;
          end
        end
        ST_BCMP: begin
          if (status.eq) begin
            start <= start - AW'(1);
            state <= ST_BACK;
          end else begin
            scan  <= CW'(start);
            state <= ST_FWD;
          end
        end
        ST_FWD: begin
          if (scan < cnt) begin
            state <= ST_FCMP;
          end else begin
            found       <= 1'b1;
            match_index <= IDX_W'(start);
            out_valid   <= 1'b1;
            state       <= ST_DONE;
          end
        end
        ST_FCMP: begin
          priority if (!status.eq) begin
            found       <= 1'b1;
            match_index <= IDX_W'(start);
            out_valid   <= 1'b1;
            state       <= ST_DONE;
          end else if (status.plat_eq) begin
            found       <= 1'b1;
            match_index <= IDX_W'(scan);
            out_valid   <= 1'b1;
            state       <= ST_DONE;
          end else begin
            scan  <= scan + CW'(1);
            state <= ST_FWD;
          end
        end
        ST_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/sgtl_checker.sv -----
// Port-level checks for the sorted identifier table lookup, bound to the top level.
module sgtl_checker import sgtl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              req_type,
  input logic              out_valid,
  input logic              out_stall,
  input logic              found,
  input logic [IDX_W-1:0]  match_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_index))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_index == '0)
    else $error("miss with nonzero index");

  a_busy_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == REQ_WRITE) |=> !out_valid)
    else $error("write item produced a result");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_guid_table_lookup_unit sgtl_checker u_sgtl_checker (.*);

// ----- sim/tb_sorted_guid_table_lookup_unit.sv -----
// Testbench for the sorted identifier table lookup unit: directed table, then random phases.
module tb_sorted_guid_table_lookup_unit;
  import sgtl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENT = 1024;
  localparam int NUM_PHASES = 10;
  localparam int EMPTY_PHASE = 3;
  localparam logic [2*GUID_W-1:0] KEY_MAX = '1;
  localparam logic [2*GUID_W-1:0] KEY_RUN = {64'h5, 64'hAAAA_AAAA_AAAA_AAAA};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic                  req;
    logic [IDX_W-1:0]      slot;
    logic [2*GUID_W-1:0]   key;
    logic [PLAT_W-1:0]     plat;
  } table_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } lookup_res_t;

  typedef struct packed {
    row_kind_t    kind;
    table_req_t   item;
    logic [CFG_W-1:0] count;
    logic         typed;
    lookup_res_t  exp;
  } row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = REQ_WRITE;
  logic [IDX_W-1:0]  entry_index = '0;
  logic [GUID_W-1:0] guid_high = '0;
  logic [GUID_W-1:0] guid_low = '0;
  logic [PLAT_W-1:0] platform_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic              found;
  logic [IDX_W-1:0]  match_index;

  logic [2*GUID_W-1:0] tbl_key [MAX_ENT];
  logic [PLAT_W-1:0]   tbl_plat [MAX_ENT];
  logic [CFG_W-1:0]    entry_count_q = '0;
  logic [2*GUID_W-1:0] sorted_keys [MAX_ENT];
  logic [2*GUID_W-1:0] pool_keys [MAX_ENT];

  lookup_res_t pending_lookups[$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;

  sorted_guid_table_lookup_unit #(.MAX_ENTRIES(MAX_ENT)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .entry_index(entry_index),
    .guid_high(guid_high),
    .guid_low(guid_low),
    .platform_code(platform_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found(found),
    .match_index(match_index)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic lookup_res_t predict_lookup(input logic [2*GUID_W-1:0] key,
                                                 input logic [PLAT_W-1:0] plat);
    int n, lo, hi, mid, hit, first, i;
    bit done;
    lookup_res_t r;
    r = '0;
    n = (entry_count_q > MAX_ENT) ? MAX_ENT : int'(entry_count_q);
    lo = 0;
    hi = n - 1;
    hit = -1;
    while (lo <= hi && hit < 0) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_key[mid] < key) lo = mid + 1;
      else if (tbl_key[mid] > key) hi = mid - 1;
      else hit = mid;
    end
    if (hit >= 0) begin
      first = hit;
      while (first > 0 && tbl_key[first - 1] == key) first--;
      r.found = 1'b1;
      r.index = first[IDX_W-1:0];
      done = 1'b0;
      for (i = first; i < n && !done && tbl_key[i] == key; i++) begin
        if (tbl_plat[i] == plat) begin
          r.index = i[IDX_W-1:0];
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [2*GUID_W-1:0] rand_key(input logic [GUID_W-1:0] shared_hi);
    logic [GUID_W-1:0] hi;
    hi = ($urandom_range(0, 1) != 0) ? shared_hi : {$urandom, $urandom};
    return {hi, $urandom, $urandom};
  endfunction

  function automatic row_t wr_row(input int slot, input logic [2*GUID_W-1:0] key,
                                  input int plat);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.req = REQ_WRITE;
    r.item.slot = slot[IDX_W-1:0];
    r.item.key = key;
    r.item.plat = plat[PLAT_W-1:0];
    return r;
  endfunction

  function automatic row_t look_row(input logic [2*GUID_W-1:0] key, input int plat);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.req = REQ_LOOKUP;
    r.item.key = key;
    r.item.plat = plat[PLAT_W-1:0];
    return r;
  endfunction

  function automatic row_t look_exp_row(input logic [2*GUID_W-1:0] key, input int plat,
                                        input logic hit, input int index);
    row_t r;
    r = look_row(key, plat);
    r.typed = 1'b1;
    r.exp.found = hit;
    r.exp.index = index[IDX_W-1:0];
    return r;
  endfunction

  function automatic row_t count_row(input int value);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.count = value[CFG_W-1:0];
    return r;
  endfunction

  task automatic send(input table_req_t it, input logic typed, input lookup_res_t exp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req;
    entry_index <= it.slot;
    guid_high <= it.key[2*GUID_W-1:GUID_W];
    guid_low <= it.key[GUID_W-1:0];
    platform_code <= it.plat;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (it.req == REQ_WRITE) begin
      tbl_key[it.slot] = it.key;
      tbl_plat[it.slot] = it.plat;
    end else begin
      pending_lookups.push_back(typed ? exp : predict_lookup(it.key, it.plat));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic set_entry_count(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    entry_count_q = value;
  endtask

  initial begin : result_check
    int w;
    lookup_res_t want;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_lookups.size() == 0) begin
        $error("unexpected result: found %0d, match_index %0d", found, match_index);
        mismatch_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          mismatch_count++;
        end
        if (match_index !== want.index) begin
          $error("match_index: expected %0d, got %0d", want.index, match_index);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t rows[$];
    table_req_t it;
    int phase, n, k, m, i, j, r, b, lim, pick;
    logic [GUID_W-1:0] shared_hi;
    logic [2*GUID_W-1:0] v;
    logic [CFG_W-1:0] cnt;

    rows.push_back(look_exp_row('0, 0, 1'b0, 0));
    rows.push_back(wr_row(0, '0, 0));
    rows.push_back(wr_row(1, 128'd1, 3));
    rows.push_back(wr_row(2, KEY_RUN, 1));
    rows.push_back(wr_row(3, KEY_RUN, 2));
    rows.push_back(wr_row(4, KEY_RUN, 7));
    rows.push_back(wr_row(5, KEY_MAX, 7));
    rows.push_back(count_row(6));
    rows.push_back(look_exp_row('0, 0, 1'b1, 0));
    rows.push_back(look_exp_row(128'd1, 3, 1'b1, 1));
    rows.push_back(look_exp_row(KEY_MAX, 7, 1'b1, 5));
    rows.push_back(look_exp_row(KEY_MAX, 0, 1'b1, 5));
    rows.push_back(look_exp_row(KEY_RUN, 7, 1'b1, 4));
    rows.push_back(look_exp_row(KEY_RUN, 2, 1'b1, 3));
    rows.push_back(look_exp_row(KEY_RUN, 5, 1'b1, 2));
    rows.push_back(look_exp_row(KEY_RUN + 1, 1, 1'b0, 0));
    rows.push_back(look_exp_row(KEY_MAX - 1, 7, 1'b0, 0));
    rows.push_back(count_row(1));
    rows.push_back(look_exp_row('0, 0, 1'b1, 0));
    rows.push_back(look_exp_row(KEY_MAX, 7, 1'b0, 0));
    rows.push_back(count_row(0));
    rows.push_back(look_exp_row('0, 0, 1'b0, 0));
    rows.push_back(wr_row(6, {64'h1, 64'h0}, 4));
    rows.push_back(wr_row(MAX_ENT - 1, KEY_MAX, 5));
    rows.push_back(count_row(7));
    rows.push_back(look_row({64'h1, 64'h0}, 4));
    rows.push_back(look_row(KEY_RUN, 7));
    rows.push_back(look_row(KEY_MAX, 7));
    for (i = 0; i < $clog2(MAX_ENT); i++) begin
      b = MAX_ENT - 1 - (MAX_ENT >> (i + 1));
      rows.push_back(wr_row(b, {64'h7, 64'(b)}, 0));
    end
    rows.push_back(count_row((1 << CFG_W) - 1));
    rows.push_back(look_exp_row(KEY_MAX, 5, 1'b1, MAX_ENT - 1));
    rows.push_back(look_exp_row(KEY_MAX, 0, 1'b1, MAX_ENT - 1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) set_entry_count(rows[i].count);
      else send(rows[i].item, rows[i].typed, rows[i].exp);
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (phase < EMPTY_PHASE) n = phase + 1;
      else n = $urandom_range(1, 40);
      k = $urandom_range(1, n);
      shared_hi = {$urandom, $urandom};
      for (i = 0; i < k; i++) pool_keys[i] = rand_key(shared_hi);
      for (i = 0; i < n; i++) sorted_keys[i] = pool_keys[$urandom_range(0, k - 1)];
      for (i = 1; i < n; i++) begin
        v = sorted_keys[i];
        b = i - 1;
        while (b >= 0 && sorted_keys[b] > v) begin
          sorted_keys[b + 1] = sorted_keys[b];
          b--;
        end
        sorted_keys[b + 1] = v;
      end
      for (i = 0; i < n; i++) begin
        it.req = REQ_WRITE;
        it.slot = i[IDX_W-1:0];
        it.key = sorted_keys[i];
        it.plat = PLAT_W'($urandom_range(0, 7));
        send(it, 1'b0, '0);
      end

      if (phase == EMPTY_PHASE) cnt = '0;
      else if ($urandom_range(0, 9) == 0) cnt = CFG_W'($urandom_range(0, n));
      else cnt = n[CFG_W-1:0];
      set_entry_count(cnt);
      lim = (cnt > MAX_ENT) ? MAX_ENT : int'(cnt);

      m = 28;
      for (j = 0; j < m; j++) begin
        if (j == m / 2 && (phase == 0 || $urandom_range(0, 1) == 0)) drain_results();
        r = $urandom_range(0, 39);
        it.req = REQ_LOOKUP;
        it.slot = IDX_W'($urandom_range(0, MAX_ENT - 1));
        it.plat = PLAT_W'($urandom_range(0, 7));
        it.key = rand_key(shared_hi);
        if (r >= 36) begin
          it.req = REQ_WRITE;
          if (r == 39) it.slot = IDX_W'($urandom_range(0, (lim > 0) ? lim - 1 : 0));
          else if (lim < MAX_ENT) it.slot = IDX_W'($urandom_range(lim, MAX_ENT - 1));
        end else if (lim > 0 && r < 32) begin
          pick = $urandom_range(0, lim - 1);
          it.key = tbl_key[pick];
          if (r < 14) it.plat = tbl_plat[pick];
          else if (r >= 28) it.key = ($urandom_range(0, 1) != 0) ? it.key + 1 : it.key - 1;
        end
        send(it, 1'b0, '0);
      end
    end

    quiet = 1'b0;
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
